// ----- design/grdc_pkg.sv -----
// shared types and constants for the grid ray dda caster
package grdc_pkg;

  localparam int MAP_W_DEF = 64;
  localparam int MAP_H_DEF = 64;

  localparam int CFG_IDX_W = 4;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_POS_X        = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POS_Y        = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DIR_X        = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DIR_Y        = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PLANE_X      = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PLANE_Y      = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_LAYER = 4'd7;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_CAST  = 1'b1;

  // shared divider: numerator and divisor widths
  localparam int DIV_NW = 31;
  localparam int DIV_DW = 16;

  localparam int DELTA_W = 41;
  localparam int SD_W = 52;
  localparam int CAM_W = 27;
  localparam int PROD_W = 49;
  localparam logic [31:0] MIN_DIST = 32'd66;

  typedef struct packed {
    logic start;
    logic done;
  } div_ctl_t;

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE, ST_CAM_DIV, ST_CAM_WAIT,
    ST_MUL_X, ST_ADD_X, ST_MUL_Y, ST_ADD_Y,
    ST_RX_DIV, ST_RX_WAIT, ST_RY_DIV, ST_RY_WAIT,
    ST_SDX_MUL, ST_SDX_SET, ST_SDY_MUL, ST_SDY_SET,
    ST_CHECK, ST_STEP, ST_BOUND, ST_TEST, ST_DONE
  } state_t;

endpackage

// ----- design/grdc_div.sv -----
// bit-serial restoring divider, one quotient bit per cycle
module grdc_div #(
  parameter int NW = grdc_pkg::DIV_NW,
  parameter int DW = grdc_pkg::DIV_DW
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [NW-1:0]       num,
  input  logic [DW-1:0]       den,
  output logic                done,
  output logic [NW-1:0]       quo
);
  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] q_r;
  logic [DW-1:0] rem_r;
  logic [DW-1:0] den_r;
  logic [CW-1:0] cnt_r;
  logic          run_r;
  logic          done_r;
  logic [DW:0]   trial;
  logic          fits;

  assign trial = {rem_r, q_r[NW-1]};
  assign fits  = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + CW'(1);
        if (cnt_r == CW'(NW - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (run_r) begin
      rem_r <= fits ? DW'(trial - {1'b0, den_r}) : trial[DW-1:0];
      q_r   <= {q_r[NW-2:0], fits};
    end
  end

  assign done = done_r;
  assign quo  = q_r;

  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r) else $error("divider done longer than one cycle");
  a_run_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> run_r) else $error("divider not running after start");
  a_done_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !run_r) else $error("divider still running at done");
endmodule

// ----- design/grid_ray_dda_caster_unit.sv -----
// top level of the grid ray dda caster
// usage: a cell map of MAP_W x MAP_H cells holds a wall bit and a creature bit each.
// an item is transferred at a rising edge with start high and busy low.
// op write stores the two bits of one cell in that same cycle and gives no result.
// op cast walks a ray for one screen column and gives one result on out_valid.
// a cast runs a setup (three serial divides on the shared divider, a divide
// skipped when its ray component is zero, four passes through the shared
// multiplier) and then its grid steps, one map read per step; up to MAP_W + MAP_H
// steps; after the walk ends the done state loads the result and out_valid registers.
// busy stays high for the whole cast, so items are taken one at a time.
// the result stands on the out_ ports for exactly one cycle with out_valid high;
// the receiver cannot stall it.
// configuration writes through cfg_we, cfg_index, cfg_wdata take effect at once; the user
// must make them while the block is idle, which the block itself does not enforce.
// after reset a clearing pass empties the map, one cell a cycle, over all
// 2^(clog2(MAP_W)+clog2(MAP_H)) cells (4096 at 64 x 64); busy is high meanwhile.
module grid_ray_dda_caster_unit #(
  parameter int MAP_W = grdc_pkg::MAP_W_DEF,
  parameter int MAP_H = grdc_pkg::MAP_H_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic                             in_op,
  input  logic [9:0]                       in_column,
  input  logic [5:0]                       in_cell_x,
  input  logic [5:0]                       in_cell_y,
  input  logic                             in_cell_wall,
  input  logic                             in_cell_creature,
  output logic                             out_valid,
  output logic                             out_hit,
  output logic                             out_side,
  output logic [5:0]                       out_map_x,
  output logic [5:0]                       out_map_y,
  output logic [31:0]                      out_perp_dist,
  input  logic                             cfg_we,
  input  logic [grdc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [grdc_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import grdc_pkg::*;

  localparam int XW = $clog2(MAP_W);
  localparam int YW = $clog2(MAP_H);
  localparam int AW = XW + YW;
  localparam int MW = $clog2(MAP_W + 64) + 1;
  localparam int MH = $clog2(MAP_H + 64) + 1;

  state_t state_r, state_nxt;

  logic [15:0] pos_x_r, pos_y_r;
  logic signed [15:0] dir_x_r, dir_y_r, plane_x_r, plane_y_r;
  logic [10:0] screen_width_r;
  logic        target_layer_r;

  logic [1:0]  mem [2**AW];
  logic [1:0]  rd_r;
  logic [AW-1:0] clr_r;

  logic [9:0]  column_r;
  logic signed [CAM_W-1:0] cam_r;
  logic signed [15:0] rx_r, ry_r;
  logic signed [PROD_W-1:0] prod_r;
  logic [DELTA_W-1:0] dx_r, dy_r;
  logic [SD_W-1:0] sdx_r, sdy_r;
  logic signed [MW-1:0] mx_r;
  logic signed [MH-1:0] my_r;
  logic side_r, hit_r;

  logic        out_valid_r, out_hit_r, out_side_r;
  logic [5:0]  out_map_x_r, out_map_y_r;
  logic [31:0] out_perp_r;

  logic div_start;
  logic div_done;
  logic [DIV_NW-1:0] div_num;
  logic [DIV_DW-1:0] div_den;
  logic [DIV_NW-1:0] div_quo;

  logic accept;
  logic signed [16:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [34:0] ray_sum;
  logic signed [15:0] ray_sat;
  logic [10:0] fx, fy;
  logic oob;
  logic [SD_W-1:0] s_sel, d_sel, diff;
  logic [31:0] perp;

  assign accept = start && (state_r == ST_IDLE);
  assign busy   = (state_r != ST_IDLE);

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_x_r        <= 16'd32768;
      pos_y_r        <= 16'd32768;
      dir_x_r        <= -16'sd16384;
      dir_y_r        <= 16'sd0;
      plane_x_r      <= 16'sd0;
      plane_y_r      <= 16'sd10813;
      screen_width_r <= 11'd320;
      target_layer_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_POS_X:        pos_x_r        <= cfg_wdata;
        REG_POS_Y:        pos_y_r        <= cfg_wdata;
        REG_DIR_X:        dir_x_r        <= $signed(cfg_wdata);
        REG_DIR_Y:        dir_y_r        <= $signed(cfg_wdata);
        REG_PLANE_X:      plane_x_r      <= $signed(cfg_wdata);
        REG_PLANE_Y:      plane_y_r      <= $signed(cfg_wdata);
        REG_SCREEN_WIDTH: screen_width_r <= cfg_wdata[10:0];
        REG_TARGET_LAYER: target_layer_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // cell map
  always_ff @(posedge clk) begin
    if (state_r == ST_CLEAR) begin
      mem[clr_r] <= 2'b00;
    end else if (accept && in_op == OP_WRITE && 32'(in_cell_x) < MAP_W
                 && 32'(in_cell_y) < MAP_H) begin
      mem[{YW'(in_cell_y), XW'(in_cell_x)}] <= {in_cell_creature, in_cell_wall};
    end
    rd_r <= mem[{YW'(my_r), XW'(mx_r)}];
  end

  // shared divider
  always_comb begin
    div_num = DIV_NW'(32'h4000_0000);
    div_den = rx_r[15] ? 16'(-rx_r) : 16'(rx_r);
    unique case (state_r)
      ST_CAM_DIV: begin
        div_num = DIV_NW'({column_r, 15'd0});
        div_den = (screen_width_r == 11'd0) ? 16'd1 : 16'(screen_width_r);
      end
      ST_RY_DIV: div_den = ry_r[15] ? 16'(-ry_r) : 16'(ry_r);
      default: ;
    endcase
  end

  grdc_div #(.NW(DIV_NW), .DW(DIV_DW)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  // shared multiplier operands
  assign fx = rx_r[15] ? {1'b0, pos_x_r[9:0]} : 11'd1024 - {1'b0, pos_x_r[9:0]};
  assign fy = ry_r[15] ? {1'b0, pos_y_r[9:0]} : 11'd1024 - {1'b0, pos_y_r[9:0]};

  always_comb begin
    mul_a = 17'(plane_x_r);
    mul_b = 32'(cam_r);
    unique case (state_r)
      ST_MUL_Y:   mul_a = 17'(plane_y_r);
      ST_SDX_MUL: begin
        mul_a = $signed({6'd0, fx});
        mul_b = $signed({1'b0, dx_r[30:0]});
      end
      ST_SDY_MUL: begin
        mul_a = $signed({6'd0, fy});
        mul_b = $signed({1'b0, dy_r[30:0]});
      end
      default: ;
    endcase
  end

  always_comb begin
    ray_sum = (state_r == ST_ADD_Y) ? 35'(dir_y_r) : 35'(dir_x_r);
    ray_sum = ray_sum + $signed(prod_r[48:14]);
    if (ray_sum > 35'sd32767) begin
      ray_sat = 16'sd32767;
    end else if (ray_sum < -35'sd32768) begin
      ray_sat = -16'sd32768;
    end else begin
      ray_sat = ray_sum[15:0];
    end
  end

  assign oob = (mx_r <= 0) || (mx_r >= $signed(MW'(MAP_W)))
            || (my_r <= 0) || (my_r >= $signed(MH'(MAP_H)));

  assign s_sel = side_r ? sdy_r : sdx_r;
  assign d_sel = side_r ? SD_W'(dy_r) : SD_W'(dx_r);
  assign diff  = s_sel - d_sel;
  always_comb begin
    if (s_sel <= d_sel || diff < SD_W'(MIN_DIST)) begin
      perp = MIN_DIST;
    end else if (diff > SD_W'(32'hFFFF_FFFF)) begin
      perp = 32'hFFFF_FFFF;
    end else begin
      perp = diff[31:0];
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    div_start = 1'b0;
    unique case (state_r)
      ST_CLEAR:    if (clr_r == '1) state_nxt = ST_IDLE;
      ST_IDLE:     if (accept && in_op == OP_CAST) state_nxt = ST_CAM_DIV;
      ST_CAM_DIV: begin
        div_start = 1'b1;
        state_nxt = ST_CAM_WAIT;
      end
      ST_CAM_WAIT: if (div_done) state_nxt = ST_MUL_X;
      ST_MUL_X:    state_nxt = ST_ADD_X;
      ST_ADD_X:    state_nxt = ST_MUL_Y;
      ST_MUL_Y:    state_nxt = ST_ADD_Y;
      ST_ADD_Y:    state_nxt = ST_RX_DIV;
      ST_RX_DIV: begin
        div_start = (rx_r != 16'sd0);
        state_nxt = (rx_r != 16'sd0) ? ST_RX_WAIT : ST_RY_DIV;
      end
      ST_RX_WAIT:  if (div_done) state_nxt = ST_RY_DIV;
      ST_RY_DIV: begin
        div_start = (ry_r != 16'sd0);
        state_nxt = (ry_r != 16'sd0) ? ST_RY_WAIT : ST_SDX_MUL;
      end
      ST_RY_WAIT:  if (div_done) state_nxt = ST_SDX_MUL;
      ST_SDX_MUL:  state_nxt = ST_SDX_SET;
      ST_SDX_SET:  state_nxt = ST_SDY_MUL;
      ST_SDY_MUL:  state_nxt = ST_SDY_SET;
      ST_SDY_SET:  state_nxt = ST_CHECK;
      ST_CHECK:    state_nxt = oob ? ST_DONE : ST_STEP;
      ST_STEP:     state_nxt = ST_BOUND;
      ST_BOUND:    state_nxt = oob ? ST_DONE : ST_TEST;
      ST_TEST: begin
        if (target_layer_r ? rd_r[1] : rd_r[0]) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_STEP;
        end
      end
      ST_DONE:     state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == ST_DONE);
      if (state_r == ST_CLEAR) clr_r <= clr_r + AW'(1);
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (accept) column_r <= in_column;
    unique case (state_r)
      ST_CAM_WAIT: cam_r <= $signed({2'b00, div_quo[24:0]}) - CAM_W'(16384);
      ST_MUL_X, ST_MUL_Y, ST_SDX_MUL, ST_SDY_MUL: prod_r <= mul_a * mul_b;
      ST_ADD_X: rx_r <= ray_sat;
      ST_ADD_Y: ry_r <= ray_sat;
      ST_RX_DIV: dx_r <= DELTA_W'(1) << 40;
      ST_RX_WAIT: if (div_done) dx_r <= DELTA_W'(div_quo);
      ST_RY_DIV: dy_r <= DELTA_W'(1) << 40;
      ST_RY_WAIT: if (div_done) dy_r <= DELTA_W'(div_quo);
      ST_SDX_SET: begin
        sdx_r <= dx_r[40] ? SD_W'(fx) << 30 : SD_W'(prod_r[47:10]);
        mx_r  <= $signed(MW'(pos_x_r[15:10]));
        side_r <= 1'b0;
        hit_r <= 1'b0;
      end
      ST_SDY_SET: begin
        sdy_r <= dy_r[40] ? SD_W'(fy) << 30 : SD_W'(prod_r[47:10]);
        my_r  <= $signed(MH'(pos_y_r[15:10]));
      end
      ST_STEP: begin
        if (sdx_r < sdy_r) begin
          sdx_r  <= sdx_r + SD_W'(dx_r);
          mx_r   <= rx_r[15] ? mx_r - MW'(1) : mx_r + MW'(1);
          side_r <= 1'b0;
        end else begin
          sdy_r  <= sdy_r + SD_W'(dy_r);
          my_r   <= ry_r[15] ? my_r - MH'(1) : my_r + MH'(1);
          side_r <= 1'b1;
        end
      end
      ST_TEST: hit_r <= target_layer_r ? rd_r[1] : rd_r[0];
      ST_DONE: begin
        out_hit_r   <= hit_r;
        out_side_r  <= side_r;
        out_map_x_r <= mx_r[5:0];
        out_map_y_r <= my_r[5:0];
        out_perp_r  <= perp;
      end
      default: ;
    endcase
  end

  assign out_valid     = out_valid_r;
  assign out_hit       = out_hit_r;
  assign out_side      = out_side_r;
  assign out_map_x     = out_map_x_r;
  assign out_map_y     = out_map_y_r;
  assign out_perp_dist = out_perp_r;

  a_result_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r) else $error("result strobe longer than one cycle");
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> state_r == ST_IDLE) else $error("result while not idle");
  a_div_expected: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == ST_CAM_WAIT || state_r == ST_RX_WAIT
                  || state_r == ST_RY_WAIT)) else $error("divider done unexpected");
  a_step_interior: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_STEP |-> $past(!oob)) else $error("step from outside interior");
endmodule

// ----- test/grid_ray_dda_caster_unit_tb.sv -----
// testbench for the grid ray dda caster: directed table, then random phases checked by a predictor
module grid_ray_dda_caster_unit_tb;
  import grdc_pkg::*;

  localparam int LIMIT = 2000000;
  localparam int SETTLE = 400;

  typedef enum logic [1:0] {RK_CFG, RK_WRITE, RK_CAST} row_kind_t;

  typedef struct {
    bit hit;
    bit side;
    bit [5:0] map_x;
    bit [5:0] map_y;
    bit [31:0] perp;
  } ray_res_t;

  typedef struct {
    row_kind_t kind;
    logic [CFG_IDX_W-1:0] idx;
    logic [15:0] data;
    logic [9:0] column;
    logic [5:0] cx;
    logic [5:0] cy;
    logic wall;
    logic crt;
    bit typed;
    ray_res_t res;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_op = OP_WRITE;
  logic [9:0] in_column = '0;
  logic [5:0] in_cell_x = '0;
  logic [5:0] in_cell_y = '0;
  logic in_cell_wall = 1'b0;
  logic in_cell_creature = 1'b0;
  logic out_valid;
  logic out_hit;
  logic out_side;
  logic [5:0] out_map_x;
  logic [5:0] out_map_y;
  logic [31:0] out_perp_dist;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  bit [1:0] cell_map [64][64];
  bit [15:0] view_px, view_py, view_dx, view_dy, view_plx, view_ply;
  bit [10:0] view_width;
  bit view_layer;

  ray_res_t pending_casts[$];
  int mismatches = 0;
  int cycles = 0;

  grid_ray_dda_caster_unit DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_op(in_op), .in_column(in_column), .in_cell_x(in_cell_x),
    .in_cell_y(in_cell_y), .in_cell_wall(in_cell_wall),
    .in_cell_creature(in_cell_creature),
    .out_valid(out_valid), .out_hit(out_hit), .out_side(out_side),
    .out_map_x(out_map_x), .out_map_y(out_map_y), .out_perp_dist(out_perp_dist),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  function automatic longint sat_q14(input longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic longint unsigned step_len(input longint r);
    longint unsigned m;
    m = (r < 0) ? -r : r;
    if (m == 0) return 64'd1 << 40;
    return (64'd1 << 30) / m;
  endfunction

  function automatic ray_res_t cast_column(input bit [9:0] col);
    ray_res_t res;
    longint w, cam, rx, ry;
    longint unsigned dx, dy, sdx, sdy, fx, fy, s, d, perp;
    int mx, my, stx, sty;
    bit side, hit;
    w = (view_width == 0) ? 1 : view_width;
    cam = ((longint'(col) << 15) / w) - 16384;
    rx = sat_q14(longint'($signed(view_dx)) + ((longint'($signed(view_plx)) * cam) >>> 14));
    ry = sat_q14(longint'($signed(view_dy)) + ((longint'($signed(view_ply)) * cam) >>> 14));
    dx = step_len(rx);
    dy = step_len(ry);
    mx = view_px[15:10];
    my = view_py[15:10];
    fx = view_px[9:0];
    fy = view_py[9:0];
    stx = (rx < 0) ? -1 : 1;
    sty = (ry < 0) ? -1 : 1;
    sdx = (((rx < 0) ? fx : 1024 - fx) * dx) >> 10;
    sdy = (((ry < 0) ? fy : 1024 - fy) * dy) >> 10;
    side = 0;
    hit = 0;
    forever begin
      if (mx <= 0 || mx >= 64 || my <= 0 || my >= 64) break;
      if (sdx < sdy) begin
        sdx += dx;
        mx += stx;
        side = 0;
      end else begin
        sdy += dy;
        my += sty;
        side = 1;
      end
      if (mx <= 0 || mx >= 64 || my <= 0 || my >= 64) break;
      if (cell_map[my][mx][view_layer]) begin
        hit = 1;
        break;
      end
    end
    s = side ? sdy : sdx;
    d = side ? dy : dx;
    perp = (s > d) ? s - d : 0;
    if (perp < 66) perp = 66;
    if (perp > 64'hFFFF_FFFF) perp = 64'hFFFF_FFFF;
    res.hit = hit;
    res.side = side;
    res.map_x = mx[5:0];
    res.map_y = my[5:0];
    res.perp = perp[31:0];
    return res;
  endfunction

  task automatic drain();
    start <= 1'b0;
    while (pending_casts.size() != 0 || busy) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    case (idx)
      REG_POS_X: view_px = data;
      REG_POS_Y: view_py = data;
      REG_DIR_X: view_dx = data;
      REG_DIR_Y: view_dy = data;
      REG_PLANE_X: view_plx = data;
      REG_PLANE_Y: view_ply = data;
      REG_SCREEN_WIDTH: view_width = data[10:0];
      REG_TARGET_LAYER: view_layer = data[0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // one transfer; a zero gap keeps start high from the previous transfer
  task automatic send_item(input logic op, input logic [9:0] col, input logic [5:0] cx,
                           input logic [5:0] cy, input logic wall, input logic crt,
                           input bit typed, input ray_res_t res);
    int gap;
    gap = $urandom_range(0, 9);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_op <= op;
    in_column <= col;
    in_cell_x <= cx;
    in_cell_y <= cy;
    in_cell_wall <= wall;
    in_cell_creature <= crt;
    do @(posedge clk); while (busy);
    if (op == OP_WRITE) cell_map[cy][cx] = {crt, wall};
    else pending_casts.push_back(typed ? res : cast_column(col));
  endtask

  always @(posedge clk) begin
    ray_res_t want;
    if (rst_n && out_valid) begin
      if (pending_casts.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: hit %0d side %0d cell %0d,%0d perp %0d",
                   out_hit, out_side, out_map_x, out_map_y, out_perp_dist);
      end else begin
        want = pending_casts.pop_front();
        if (out_hit !== want.hit || out_side !== want.side || out_map_x !== want.map_x ||
            out_map_y !== want.map_y || out_perp_dist !== want.perp) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"cast mismatch: expected hit %0d side %0d cell %0d,%0d perp %0d,",
                      " got hit %0d side %0d cell %0d,%0d perp %0d"},
                     want.hit, want.side, want.map_x, want.map_y, want.perp,
                     out_hit, out_side, out_map_x, out_map_y, out_perp_dist);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    stim_row_t rows[$];
    stim_row_t r;
    ray_res_t none;
    ray_res_t hit_left;
    ray_res_t off_map;
    int sel;
    logic [9:0] col;
    none = '{0, 0, 0, 0, 0};
    hit_left = '{1, 0, 6'd31, 6'd32, 32'd66};
    off_map = '{0, 0, 6'd0, 6'd32, 32'd66};
    view_px = 16'd32768;
    view_py = 16'd32768;
    view_dx = 16'hC000;
    view_dy = 16'd0;
    view_plx = 16'd0;
    view_ply = 16'd10813;
    view_width = 11'd320;
    view_layer = 1'b0;

    rows = '{
      '{RK_CAST, 0, 0, 10'd0, 0, 0, 0, 0, 0, none},
      '{RK_CAST, 0, 0, 10'd319, 0, 0, 0, 0, 0, none},
      '{RK_WRITE, 0, 0, 0, 6'd0, 6'd0, 1, 1, 0, none},
      '{RK_WRITE, 0, 0, 0, 6'd63, 6'd63, 1, 1, 0, none},
      '{RK_WRITE, 0, 0, 0, 6'd31, 6'd32, 1, 0, 0, none},
      '{RK_CAST, 0, 0, 10'd160, 0, 0, 0, 0, 1, hit_left},
      '{RK_WRITE, 0, 0, 0, 6'd31, 6'd32, 0, 1, 0, none},
      '{RK_CAST, 0, 0, 10'd160, 0, 0, 0, 0, 0, none},
      '{RK_CFG, REG_TARGET_LAYER, 16'hFFFF, 0, 0, 0, 0, 0, 0, none},
      '{RK_CAST, 0, 0, 10'd160, 0, 0, 0, 0, 1, hit_left},
      '{RK_CFG, REG_SCREEN_WIDTH, 16'd0, 0, 0, 0, 0, 0, 0, none},
      '{RK_CAST, 0, 0, 10'd1023, 0, 0, 0, 0, 0, none},
      '{RK_CAST, 0, 0, 10'd0, 0, 0, 0, 0, 0, none},
      '{RK_CFG, REG_TARGET_LAYER + 4'd1, 16'h1234, 0, 0, 0, 0, 0, 0, none},
      '{RK_CFG, REG_POS_X, 16'd0, 0, 0, 0, 0, 0, 0, none},
      '{RK_CAST, 0, 0, 10'd5, 0, 0, 0, 0, 1, off_map},
      '{RK_CFG, REG_POS_X, 16'hFFFF, 0, 0, 0, 0, 0, 0, none},
      '{RK_CFG, REG_DIR_X, 16'h7FFF, 0, 0, 0, 0, 0, 0, none},
      '{RK_CFG, REG_DIR_Y, 16'h8000, 0, 0, 0, 0, 0, 0, none},
      '{RK_CFG, REG_PLANE_X, 16'h8000, 0, 0, 0, 0, 0, 0, none},
      '{RK_CFG, REG_PLANE_Y, 16'h7FFF, 0, 0, 0, 0, 0, 0, none},
      '{RK_CFG, REG_SCREEN_WIDTH, 16'd1024, 0, 0, 0, 0, 0, 0, none},
      '{RK_CAST, 0, 0, 10'd1023, 0, 0, 0, 0, 0, none},
      '{RK_CFG, REG_POS_Y, 16'hFFFF, 0, 0, 0, 0, 0, 0, none},
      '{RK_CAST, 0, 0, 10'd512, 0, 0, 0, 0, 0, none}
    };

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) begin
      r = rows[i];
      if (r.kind == RK_CFG) begin
        drain();
        cfg_write(r.idx, r.data);
      end else begin
        send_item(r.kind == RK_CAST ? OP_CAST : OP_WRITE, r.column, r.cx, r.cy,
                  r.wall, r.crt, r.typed, r.res);
      end
    end

    for (int ph = 0; ph < 6; ph++) begin
      drain();
      sel = $urandom_range(0, 3);
      cfg_write(REG_POS_X, sel == 0 ? 16'($urandom) : 16'($urandom_range(1024, 64511)));
      cfg_write(REG_POS_Y, sel == 1 ? 16'($urandom) : 16'($urandom_range(1024, 64511)));
      cfg_write(REG_DIR_X, 16'($urandom));
      cfg_write(REG_DIR_Y, 16'($urandom));
      cfg_write(REG_PLANE_X, 16'($urandom));
      cfg_write(REG_PLANE_Y, 16'($urandom));
      cfg_write(REG_SCREEN_WIDTH, sel == 2 ? 16'($urandom) : 16'($urandom_range(1, 1024)));
      cfg_write(REG_TARGET_LAYER, 16'($urandom));
      for (int k = 0; k < 100; k++) begin
        if ($urandom_range(0, 3) == 0) begin
          send_item(OP_WRITE, 10'($urandom), 6'($urandom), 6'($urandom),
                    $urandom_range(0, 5) == 0, $urandom_range(0, 5) == 0, 0, none);
        end else begin
          if ($urandom_range(0, 7) == 0 || view_width < 2) col = 10'($urandom);
          else col = 10'($urandom_range(0, (view_width > 1024 ? 1024 : view_width) - 1));
          send_item(OP_CAST, col, 6'($urandom), 6'($urandom), 1'($urandom), 1'($urandom),
                    0, none);
        end
      end
    end

    drain();
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
design/grdc_pkg.sv
design/grdc_div.sv
design/grid_ray_dda_caster_unit.sv
test/grid_ray_dda_caster_unit_tb.sv
